[hdl/mi3_pkg.sv]
// Shared constants and width helpers for the 3x3 adjugate matrix inverse.
// Used by every module of the block; depends on nothing.
package mi3_pkg;

  localparam int ELEM_W_DEF = 16;
  localparam int N_DIM      = 3;
  localparam int N_ELEM     = 9;
  localparam int OUT_W      = 32;
  localparam int OUT_FRAC   = 16;
  localparam int DET_OUT_W  = 49;
  localparam int QBITS      = 31;
  localparam int WRAP_W     = 64;
  localparam int OUT_TDATA_W = ((N_ELEM * OUT_W + DET_OUT_W + 7) / 8) * 8;

  localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

  function automatic int cof_w(input int w);
    return 2 * w + 1;
  endfunction

  // determinant width, wrapped to the 64-bit working range
  function automatic int det_w(input int w);
    int s;
    s = w + cof_w(w) + 2;
    return (s > WRAP_W) ? WRAP_W : s;
  endfunction

  // numerator (cofactor shifted up) width, wrapped to 64 bits
  function automatic int num_w(input int w, input int sh);
    int s;
    s = cof_w(w) + sh;
    return (s > WRAP_W) ? WRAP_W : s;
  endfunction

endpackage

[hdl/mi3_cofactor.sv]
// Two-stage cofactor unit: eighteen element products, then nine cyclic cofactors.
// Depends on mi3_pkg.
module mi3_cofactor #(
  parameter int W = mi3_pkg::ELEM_W_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [W-1:0]               a [mi3_pkg::N_ELEM],
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mi3_pkg::cof_w(W)-1:0] cof [mi3_pkg::N_ELEM],
  output logic signed [W-1:0]               a0 [mi3_pkg::N_DIM]
);
  localparam int NE = mi3_pkg::N_ELEM;
  localparam int ND = mi3_pkg::N_DIM;
  localparam int PW = 2 * W;
  localparam int CW = mi3_pkg::cof_w(W);

  logic                v1_r, v2_r, rdy1, rdy2;
  logic signed [PW-1:0] pp_nxt [NE];
  logic signed [PW-1:0] pn_nxt [NE];
  logic signed [PW-1:0] pp_r [NE];
  logic signed [PW-1:0] pn_r [NE];
  logic signed [CW-1:0] cof_nxt [NE];
  logic signed [CW-1:0] cof_r [NE];
  logic signed [W-1:0]  a0_1_r [ND];
  logic signed [W-1:0]  a0_2_r [ND];

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  for (genvar k = 0; k < NE; k++) begin : g_prod
    localparam int R  = k / ND;
    localparam int C  = k % ND;
    localparam int R1 = (R + 1) % ND;
    localparam int R2 = (R + 2) % ND;
    localparam int C1 = (C + 1) % ND;
    localparam int C2 = (C + 2) % ND;
    assign pp_nxt[k]  = a[R1*ND+C1] * a[R2*ND+C2];
    assign pn_nxt[k]  = a[R1*ND+C2] * a[R2*ND+C1];
    assign cof_nxt[k] = CW'(pp_r[k]) - CW'(pn_r[k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      pp_r   <= pp_nxt;
      pn_r   <= pn_nxt;
      a0_1_r <= a[0:ND-1];
    end
    if (v1_r && rdy2) begin
      cof_r  <= cof_nxt;
      a0_2_r <= a0_1_r;
    end
  end

  assign out_valid = v2_r;
  assign cof       = cof_r;
  assign a0        = a0_2_r;

endmodule

[hdl/mi3_det.sv]
// Three-stage determinant unit: row-0 products, sum, then divider operands
// (magnitudes and quotient signs of the transposed cofactors). Depends on mi3_pkg.
module mi3_det #(
  parameter int W  = mi3_pkg::ELEM_W_DEF,
  parameter int SH = mi3_pkg::ELEM_W_DEF / 2 + mi3_pkg::OUT_FRAC
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [mi3_pkg::cof_w(W)-1:0]    cof [mi3_pkg::N_ELEM],
  input  logic signed [W-1:0]                    a0 [mi3_pkg::N_DIM],
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [mi3_pkg::num_w(W, SH)-1:0]       num_mag [mi3_pkg::N_ELEM],
  output logic                                   neg [mi3_pkg::N_ELEM],
  output logic [mi3_pkg::det_w(W)-1:0]           den_mag,
  output logic [mi3_pkg::det_w(W)-1:0]           det,
  output logic                                   zero
);
  localparam int NE    = mi3_pkg::N_ELEM;
  localparam int ND    = mi3_pkg::N_DIM;
  localparam int CW    = mi3_pkg::cof_w(W);
  localparam int DPW   = W + CW;
  localparam int SUM_W = DPW + 2;
  localparam int DW    = mi3_pkg::det_w(W);
  localparam int NAT_W = CW + SH;
  localparam int NW    = mi3_pkg::num_w(W, SH);

  logic                  v3_r, v4_r, v5_r, rdy3, rdy4, rdy5;
  logic signed [DPW-1:0] dp_nxt [ND];
  logic signed [DPW-1:0] dp_r [ND];
  logic signed [CW-1:0]  cof3_r [NE];
  logic signed [CW-1:0]  cof4_r [NE];
  logic signed [SUM_W-1:0] sum_full;
  logic [DW-1:0]         det4_r, det5_r, den_nxt, den_r;
  logic                  zero_r;
  logic [NW-1:0]         mag_nxt [NE];
  logic [NW-1:0]         mag_r [NE];
  logic                  neg_nxt [NE];
  logic                  neg_r [NE];

  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign in_ready = rdy3;

  for (genvar c = 0; c < ND; c++) begin : g_dp
    assign dp_nxt[c] = DPW'(a0[c]) * DPW'(cof[c]);
  end

  assign sum_full = SUM_W'(dp_r[0]) + SUM_W'(dp_r[1]) + SUM_W'(dp_r[2]);
  assign den_nxt  = det4_r[DW-1] ? (DW'(0) - det4_r) : det4_r;

  // inverse element (r,c) divides cofactor (c,r)
  for (genvar k = 0; k < NE; k++) begin : g_num
    localparam int T = (k % ND) * ND + k / ND;
    logic [NAT_W-1:0] nat;
    logic [NW-1:0]    nv;
    assign nat        = {cof4_r[T], {SH{1'b0}}};
    assign nv         = nat[NW-1:0];
    assign mag_nxt[k] = nv[NW-1] ? (NW'(0) - nv) : nv;
    assign neg_nxt[k] = nv[NW-1] ^ det4_r[DW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy3) v3_r <= in_valid;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy3) begin
      dp_r   <= dp_nxt;
      cof3_r <= cof;
    end
    if (v3_r && rdy4) begin
      det4_r <= sum_full[DW-1:0];
      cof4_r <= cof3_r;
    end
    if (v4_r && rdy5) begin
      det5_r <= det4_r;
      den_r  <= den_nxt;
      zero_r <= (det4_r == '0);
      mag_r  <= mag_nxt;
      neg_r  <= neg_nxt;
    end
  end

  assign out_valid = v5_r;
  assign num_mag   = mag_r;
  assign neg       = neg_r;
  assign den_mag   = den_r;
  assign det       = det5_r;
  assign zero      = zero_r;

endmodule

[hdl/mi3_div.sv]
// Pipelined restoring divider for nine lanes sharing one divisor: a saturation
// check stage, then one quotient bit per stage. Depends on mi3_pkg.
module mi3_div #(
  parameter int NUM_W = mi3_pkg::num_w(mi3_pkg::ELEM_W_DEF,
                                       mi3_pkg::ELEM_W_DEF / 2 + mi3_pkg::OUT_FRAC),
  parameter int DET_W = mi3_pkg::det_w(mi3_pkg::ELEM_W_DEF)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [NUM_W-1:0]           num_mag [mi3_pkg::N_ELEM],
  input  logic                       neg [mi3_pkg::N_ELEM],
  input  logic [DET_W-1:0]           den_mag,
  input  logic [DET_W-1:0]           det,
  input  logic                       zero,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mi3_pkg::QBITS-1:0]  quo [mi3_pkg::N_ELEM],
  output logic                       ovf [mi3_pkg::N_ELEM],
  output logic                       neg_o [mi3_pkg::N_ELEM],
  output logic [DET_W-1:0]           det_o,
  output logic                       zero_o
);
  localparam int NE    = mi3_pkg::N_ELEM;
  localparam int QB    = mi3_pkg::QBITS;
  localparam int CMP_W = (NUM_W > DET_W + QB) ? NUM_W : DET_W + QB;

  logic             v_r   [QB+1];
  logic             rdy   [QB+1];
  logic [NUM_W-1:0] rem_r [QB+1][NE];
  logic [QB-1:0]    quo_r [QB+1][NE];
  logic             ovf_r [QB+1][NE];
  logic             neg_r [QB+1][NE];
  logic [DET_W-1:0] den_r [QB+1];
  logic [DET_W-1:0] det_r [QB+1];
  logic             zero_r [QB+1];
  logic             ovf_nxt [NE];

  assign rdy[QB]  = !v_r[QB] || out_ready;
  assign in_ready = rdy[0];

  // quotient of 2^31 or more saturates
  for (genvar l = 0; l < NE; l++) begin : g_ovf
    assign ovf_nxt[l] = CMP_W'(num_mag[l]) >= (CMP_W'(den_mag) << QB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy[0]) begin
      for (int l = 0; l < NE; l++) begin
        rem_r[0][l] <= num_mag[l];
        quo_r[0][l] <= '0;
        ovf_r[0][l] <= ovf_nxt[l];
        neg_r[0][l] <= neg[l];
      end
      den_r[0]  <= den_mag;
      det_r[0]  <= det;
      zero_r[0] <= zero;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    localparam int K = QB - 1 - s;
    logic [CMP_W-1:0] dsh;
    logic             take [NE];
    logic [NUM_W-1:0] rem_nxt [NE];
    logic [QB-1:0]    quo_nxt [NE];

    if (s < QB - 1) begin : g_rdy
      assign rdy[s] = !v_r[s] || rdy[s+1];
    end

    assign dsh = CMP_W'(den_r[s]) << K;

    for (genvar l = 0; l < NE; l++) begin : g_lane
      logic [CMP_W-1:0] diff;
      assign take[l]    = CMP_W'(rem_r[s][l]) >= dsh;
      assign diff       = CMP_W'(rem_r[s][l]) - dsh;
      assign rem_nxt[l] = take[l] ? diff[NUM_W-1:0] : rem_r[s][l];
      assign quo_nxt[l] = quo_r[s][l] | (QB'(take[l]) << K);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (rdy[s+1]) begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (v_r[s] && rdy[s+1]) begin
        for (int l = 0; l < NE; l++) begin
          rem_r[s+1][l] <= rem_nxt[l];
          quo_r[s+1][l] <= quo_nxt[l];
          ovf_r[s+1][l] <= ovf_r[s][l];
          neg_r[s+1][l] <= neg_r[s][l];
        end
        den_r[s+1]  <= den_r[s];
        det_r[s+1]  <= det_r[s];
        zero_r[s+1] <= zero_r[s];
      end
    end
  end

  assign rdy[QB-1] = !v_r[QB-1] || rdy[QB];

  assign out_valid = v_r[QB];
  assign quo       = quo_r[QB];
  assign ovf       = ovf_r[QB];
  assign neg_o     = neg_r[QB];
  assign det_o     = det_r[QB];
  assign zero_o    = zero_r[QB];

endmodule

[hdl/matrix_inverse_3x3.sv]
// Top level of the 3x3 adjugate matrix inverse: cofactor, determinant and divider
// pipelines plus the saturating output register. Depends on mi3_pkg and all mi3_ modules.
//
//   channel  | ports           | payload
//   input    | in_t*           | nine signed elements a_00..a_22
//   result   | out_t*          | nine Q16.16 inverse elements, Q25.24 determinant, singular
//
// One matrix per cycle enters unless out_tready stalls the pipeline; each result runs
// via 2 cofactor, 3 determinant, 1 saturation check, 31 quotient-bit, 1 output stages.
// Every stage holds its own valid bit and fills a bubble even while the result waits.
// rst_n is synchronous and clears only the valid bits.
// An out_tready stall holds occupied stages up to a bubble; nothing is lost or repeated.
module matrix_inverse_3x3 #(
  parameter int ELEM_WIDTH = mi3_pkg::ELEM_W_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22 (ELEM_WIDTH each), zero pad
  input  logic [((mi3_pkg::N_ELEM*ELEM_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // inv_00 .. inv_22 (32 each), determinant (49), zero pad
  output logic [mi3_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // singular
  output logic [0:0]                            out_tuser
);
  localparam int NE   = mi3_pkg::N_ELEM;
  localparam int ND   = mi3_pkg::N_DIM;
  localparam int OW   = mi3_pkg::OUT_W;
  localparam int QB   = mi3_pkg::QBITS;
  localparam int DOW  = mi3_pkg::DET_OUT_W;
  localparam int SH   = ELEM_WIDTH / 2 + mi3_pkg::OUT_FRAC;
  localparam int CW   = mi3_pkg::cof_w(ELEM_WIDTH);
  localparam int DW   = mi3_pkg::det_w(ELEM_WIDTH);
  localparam int NW   = mi3_pkg::num_w(ELEM_WIDTH, SH);
  localparam int DLO  = NE * OW;
  localparam int TDW  = mi3_pkg::OUT_TDATA_W;

  logic signed [ELEM_WIDTH-1:0] a [NE];
  logic signed [CW-1:0]         cof [NE];
  logic signed [ELEM_WIDTH-1:0] a0 [ND];
  logic                         cf_valid, cf_ready;
  logic [NW-1:0]                num_mag [NE];
  logic                         neg [NE];
  logic [DW-1:0]                den_mag, det;
  logic                         zero;
  logic                         dt_valid, dt_ready;
  logic [QB-1:0]                quo [NE];
  logic                         ovf [NE];
  logic                         qneg [NE];
  logic [DW-1:0]                qdet;
  logic                         qzero;
  logic                         dv_valid, dv_ready;
  logic [OW-1:0]                inv_nxt [NE];
  logic [OW-1:0]                inv_r [NE];
  logic [DOW-1:0]               det_nxt, det_r;
  logic                         sing_r, out_v_r;

  for (genvar k = 0; k < NE; k++) begin : g_unpack
    assign a[k] = in_tdata[k*ELEM_WIDTH +: ELEM_WIDTH];
  end

  mi3_cofactor #(.W(ELEM_WIDTH)) u_cofactor (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .a         (a),
    .out_valid (cf_valid),
    .out_ready (cf_ready),
    .cof       (cof),
    .a0        (a0)
  );

  mi3_det #(.W(ELEM_WIDTH), .SH(SH)) u_det (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cf_valid),
    .in_ready  (cf_ready),
    .cof       (cof),
    .a0        (a0),
    .out_valid (dt_valid),
    .out_ready (dt_ready),
    .num_mag   (num_mag),
    .neg       (neg),
    .den_mag   (den_mag),
    .det       (det),
    .zero      (zero)
  );

  mi3_div #(.NUM_W(NW), .DET_W(DW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dt_valid),
    .in_ready  (dt_ready),
    .num_mag   (num_mag),
    .neg       (neg),
    .den_mag   (den_mag),
    .det       (det),
    .zero      (zero),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .quo       (quo),
    .ovf       (ovf),
    .neg_o     (qneg),
    .det_o     (qdet),
    .zero_o    (qzero)
  );

  // apply sign and saturate; a singular matrix gives all zeros
  for (genvar k = 0; k < NE; k++) begin : g_sat
    logic [OW-1:0] mag;
    assign mag = OW'(quo[k]);
    always_comb begin
      if (qzero) begin
        inv_nxt[k] = '0;
      end else if (qneg[k]) begin
        inv_nxt[k] = ovf[k] ? mi3_pkg::SAT_NEG : (OW'(0) - mag);
      end else begin
        inv_nxt[k] = ovf[k] ? mi3_pkg::SAT_POS : mag;
      end
    end
  end

  if (DW >= DOW) begin : g_det_trunc
    assign det_nxt = qdet[DOW-1:0];
  end else begin : g_det_ext
    assign det_nxt = DOW'($signed(qdet));
  end

  assign dv_ready = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (dv_ready) begin
      out_v_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_valid && dv_ready) begin
      inv_r  <= inv_nxt;
      det_r  <= det_nxt;
      sing_r <= qzero;
    end
  end

  for (genvar k = 0; k < NE; k++) begin : g_pack
    assign out_tdata[k*OW +: OW] = inv_r[k];
  end
  assign out_tdata[DLO +: DOW]     = det_r;
  assign out_tdata[TDW-1:DLO+DOW]  = '0;
  assign out_tuser[0]              = sing_r;
  assign out_tvalid                = out_v_r;

  a_sing_det_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[DLO +: DOW] == '0)
    else $error("singular result with nonzero determinant");

  a_sing_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[DLO-1:0] == '0)
    else $error("singular result with nonzero inverse");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

[sim/mi3_checker.sv]
// Watches both channels of the 3x3 matrix inverse, predicts each result from the
// accepted matrix and compares field by field. Depends on mi3_pkg.
module mi3_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [143:0]                    in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [mi3_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [0:0]                      out_tuser,
  output int                              fail_count,
  output int                              pending,
  output int                              seen_singular,
  output int                              seen_sat
);
  typedef struct packed {
    logic [mi3_pkg::N_ELEM-1:0][mi3_pkg::OUT_W-1:0] inv;
    logic [mi3_pkg::DET_OUT_W-1:0]                   det;
    logic                                            sing;
  } inv_result_t;

  inv_result_t inverse_queue[$];

  function automatic logic [63:0] elem(input logic [143:0] d, input int r, input int c);
    return {{48{d[(r*3+c)*16+15]}}, d[(r*3+c)*16 +: 16]};
  endfunction

  function automatic logic [31:0] div_sat(input logic [63:0] num, input logic [63:0] den);
    logic neg;
    logic [63:0] q, mn, md;
    neg = num[63] ^ den[63];
    mn = num[63] ? -num : num;
    md = den[63] ? -den : den;
    q = mn / md;
    if (neg) return (q >= 64'h8000_0000) ? mi3_pkg::SAT_NEG : 32'(-q);
    return (q > 64'h7FFF_FFFF) ? mi3_pkg::SAT_POS : q[31:0];
  endfunction

  function automatic inv_result_t invert(input logic [143:0] d);
    inv_result_t res;
    logic [63:0] cof[3][3];
    logic [63:0] det;
    det = 0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        cof[r][c] = elem(d, (r+1)%3, (c+1)%3) * elem(d, (r+2)%3, (c+2)%3)
                  - elem(d, (r+1)%3, (c+2)%3) * elem(d, (r+2)%3, (c+1)%3);
    for (int c = 0; c < 3; c++) det += elem(d, 0, c) * cof[0][c];
    res = '0;
    if (det == 0) begin
      res.sing = 1'b1;
      return res;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        res.inv[r*3+c] = div_sat(cof[c][r] << 24, det);
    res.det = det[mi3_pkg::DET_OUT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    inv_result_t exp_r;
    logic [mi3_pkg::OUT_W-1:0] got;
    int nfail, nsat;
    nfail = 0;
    nsat  = 0;
    if (!rst_n) begin
      fail_count    <= 0;
      seen_singular <= 0;
      seen_sat      <= 0;
    end else begin
      if (in_tvalid && in_tready) inverse_queue.push_back(invert(in_tdata));
      if (out_tvalid && out_tready) begin
        if (inverse_queue.size() == 0) begin
          $error("result with no matrix pending");
          nfail++;
        end else begin
          exp_r = inverse_queue.pop_front();
          if (exp_r.sing) seen_singular <= seen_singular + 1;
          for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
            got = out_tdata[k*mi3_pkg::OUT_W +: mi3_pkg::OUT_W];
            if (exp_r.inv[k] == mi3_pkg::SAT_POS || exp_r.inv[k] == mi3_pkg::SAT_NEG)
              nsat++;
            if (got !== exp_r.inv[k]) begin
              $error("inv_%0d%0d expected %h got %h", k/3, k%3, exp_r.inv[k], got);
              nfail++;
            end
          end
          if (out_tdata[mi3_pkg::N_ELEM*mi3_pkg::OUT_W +: mi3_pkg::DET_OUT_W]
              !== exp_r.det) begin
            $error("determinant expected %h got %h", exp_r.det,
                   out_tdata[mi3_pkg::N_ELEM*mi3_pkg::OUT_W +: mi3_pkg::DET_OUT_W]);
            nfail++;
          end
          if (out_tuser[0] !== exp_r.sing) begin
            $error("singular expected %b got %b", exp_r.sing, out_tuser[0]);
            nfail++;
          end
        end
      end
      fail_count <= fail_count + nfail;
      seen_sat   <= seen_sat + nsat;
    end
    pending <= inverse_queue.size();
  end
endmodule

[sim/tb_top.sv]
// Stimulus and verdict for the 3x3 matrix inverse: directed and random matrices
// under varying idle patterns. Depends on mi3_pkg, matrix_inverse_3x3 and mi3_checker.
module tb_top;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [143:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [mi3_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [0:0] out_tuser;
  int fail_count, pending, seen_singular, seen_sat;
  int send_idle = 0, recv_idle = 0;
  int sent = 0;

  always #6 clk = ~clk;

  matrix_inverse_3x3 i_dut (.*);

  mi3_checker i_chk (.*);

  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= recv_idle);

  function automatic logic [15:0] rnd_elem(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(1024)) - 512);
      2: return ($urandom_range(1)) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom_range(3)) - 16'd1;
    endcase
  endfunction

  // drop valid only while idling, so back to back requests keep it high
  task automatic send_matrix(input logic [143:0] m);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= m;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [143:0] diag(input logic [15:0] a, input logic [15:0] b,
                                        input logic [15:0] c);
    logic [143:0] m;
    m = '0;
    m[0 +: 16] = a;
    m[64 +: 16] = b;
    m[128 +: 16] = c;
    return m;
  endfunction

  task automatic random_phase(input int n);
    logic [143:0] m;
    int mode;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(3);
      for (int k = 0; k < 9; k++) m[k*16 +: 16] = rnd_elem(mode);
      // copy a row now and then to force singular matrices
      if ($urandom_range(9) == 0) m[48 +: 48] = m[0 +: 48];
      send_matrix(m);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle = 32;
    recv_idle = 49;
    send_matrix(diag(16'h0100, 16'h0100, 16'h0100));
    send_matrix(diag(16'h0200, 16'hFF00, 16'h0080));
    send_matrix(diag(16'h0001, 16'h0001, 16'h0001));
    send_matrix(diag(16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_matrix(diag(16'h8000, 16'h8000, 16'h8000));
    send_matrix(diag(16'h8000, 16'h7FFF, 16'h0001));
    send_matrix('0);
    send_matrix({144{1'b1}});
    send_matrix({9{16'h8000}});
    send_matrix({9{16'h7FFF}});
    send_matrix({16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100,
                 16'h0000, 16'h0100, 16'h0000});
    send_matrix({8{16'h5555, 16'hAAAA}} >> 16);
    random_phase(520);
    send_idle = 49;
    recv_idle = 32;
    random_phase(560);
    send_idle = 0;
    recv_idle = 0;
    random_phase(560);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d matrices, %0d singular, %0d saturated inverse entries",
             sent, seen_singular, seen_sat);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

[matrix_inverse_3x3.f]
hdl/mi3_pkg.sv
hdl/mi3_cofactor.sv
hdl/mi3_det.sv
hdl/mi3_div.sv
hdl/matrix_inverse_3x3.sv
sim/mi3_checker.sv
sim/tb_top.sv
